FILE: design/sppq_pkg.sv
// shared types, constants and codes of the strict priority paced queue
`timescale 1ns / 1ps

package sppq_pkg;

  localparam int TIME_W   = 48;
  localparam int HANDLE_W = 16;
  localparam int PORT_W   = 16;
  localparam int PRIO_W   = 8;
  localparam int LEVEL_W  = 2;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 7;
  localparam int DELAY_W  = 32;
  localparam int ENTRY_W  = HANDLE_W + TIME_W;

  localparam int NUM_LEVEL_REGS    = 4;
  localparam int NUM_REGS          = 8;
  localparam int REG_CAPACITY_BASE = 0;
  localparam int REG_DELAY_BASE    = 4;
  localparam int REG_IDX_W         = 3;
  localparam int PADDR_W           = 5;
  localparam int PDATA_W           = 32;

  localparam int LEVELS_DEFAULT      = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 64;
  localparam int PORT_COUNT_DEFAULT  = 16;

  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 7'd64;
  localparam logic [DELAY_W-1:0] DELAY_RESET    = '0;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_BAD_PORT = 3'd2,
    ST_UNTAGGED = 3'd3,
    ST_DEQUEUED = 3'd4,
    ST_NONE     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_CHK,
    S_ENQ_WR,
    S_DEQ_RD,
    S_DEQ_CMP,
    S_FINISH
  } state_t;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_CMP
  } alu_mode_t;

  typedef struct packed {
    logic                kind;
    logic [TIME_W-1:0]   current_time;
    logic                has_tag;
    logic [PRIO_W-1:0]   tag_priority;
    logic [PORT_W-1:0]   tag_port;
    logic [HANDLE_W-1:0] packet_handle;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] packet_out;
    logic [LEVEL_W-1:0]  level_out;
  } rsp_t;

  typedef struct packed {
    alu_mode_t         mode;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

endpackage

FILE: design/strict_priority_paced_queue_core.sv
// top level: config registers, packet store, shared adder and sequencer
// enqueue: checked in S_ENQ_CHK; stored in S_ENQ_WR unless rejected
// dequeue: scans levels from 0 up; S_DEQ_RD skips an empty level, and a
// level whose head is read from the packet store is compared on the adder
// one request at a time; a new request is taken while the last result waits
// reset clears queue pointers and counts, capacities to 64, delays to 0
`timescale 1ns / 1ps

module strict_priority_paced_queue_core #(
  parameter int LEVELS      = sppq_pkg::LEVELS_DEFAULT,
  parameter int QUEUE_DEPTH = sppq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int PORT_COUNT  = sppq_pkg::PORT_COUNT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  sppq_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output sppq_pkg::rsp_t               rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sppq_pkg::PADDR_W-1:0] paddr,
  input  logic [sppq_pkg::PDATA_W-1:0] pwdata,
  output logic [sppq_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int LVL_AW = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = LVL_AW + PTR_W;

  logic [sppq_pkg::CAP_W-1:0]   capacity [sppq_pkg::NUM_LEVEL_REGS];
  logic [sppq_pkg::DELAY_W-1:0] delay [sppq_pkg::NUM_LEVEL_REGS];

  logic [sppq_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           reg_is_delay;
  logic                           cfg_wr;

  sppq_pkg::alu_req_t           alu_op;
  sppq_pkg::alu_rsp_t           alu_res;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [sppq_pkg::ENTRY_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_raddr;
  logic [sppq_pkg::ENTRY_W-1:0] mem_rdata;

  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign reg_idx      = paddr[sppq_pkg::PADDR_W-1:2];
  assign reg_is_delay = reg_idx >= sppq_pkg::REG_IDX_W'(sppq_pkg::REG_DELAY_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sppq_pkg::NUM_LEVEL_REGS; i++) begin
        capacity[i] <= sppq_pkg::CAPACITY_RESET;
        delay[i]    <= sppq_pkg::DELAY_RESET;
      end
    end else if (cfg_wr) begin
      if (reg_is_delay) begin
        delay[reg_idx[1:0]] <= pwdata[sppq_pkg::DELAY_W-1:0];
      end else begin
        capacity[reg_idx[1:0]] <= pwdata[sppq_pkg::CAP_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_is_delay) begin
      prdata = sppq_pkg::PDATA_W'(delay[reg_idx[1:0]]);
    end else begin
      prdata = sppq_pkg::PDATA_W'(capacity[reg_idx[1:0]]);
    end
  end

  sppq_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  sppq_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sppq_seq #(
    .LEVELS      (LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PORT_COUNT  (PORT_COUNT),
    .LVL_AW      (LVL_AW),
    .PTR_W       (PTR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .capacity  (capacity),
    .delay     (delay),
    .alu_op    (alu_op),
    .alu_res   (alu_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

FILE: design/sppq_alu.sv
// shared 48-bit adder: saturating release time add or due time compare
`timescale 1ns / 1ps

module sppq_alu (
  input  sppq_pkg::alu_req_t op,
  output sppq_pkg::alu_rsp_t res
);

  logic                      sub;
  logic [sppq_pkg::TIME_W:0] total;

  assign sub   = (op.mode == sppq_pkg::ALU_CMP);
  assign total = {1'b0, op.a} + {1'b0, (sub ? ~op.b : op.b)} + {{sppq_pkg::TIME_W{1'b0}}, sub};

  // add: carry is overflow; compare: carry means a >= b
  always_comb begin
    res.carry = total[sppq_pkg::TIME_W];
    if (!sub && total[sppq_pkg::TIME_W]) begin
      res.sum = '1;
    end else begin
      res.sum = total[sppq_pkg::TIME_W-1:0];
    end
  end

endmodule

FILE: design/sppq_store.sv
// packet store memory, one write and one registered read port
`timescale 1ns / 1ps

module sppq_store #(
  parameter int ADDR_W = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [sppq_pkg::ENTRY_W-1:0] wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [sppq_pkg::ENTRY_W-1:0] rdata
);

  logic [sppq_pkg::ENTRY_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sppq_seq.sv
// sequencer: per-level queue pointers, level scan and result register
`timescale 1ns / 1ps

module sppq_seq #(
  parameter int LEVELS      = sppq_pkg::LEVELS_DEFAULT,
  parameter int QUEUE_DEPTH = sppq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int PORT_COUNT  = sppq_pkg::PORT_COUNT_DEFAULT,
  parameter int LVL_AW      = $clog2(LEVELS),
  parameter int PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  sppq_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output sppq_pkg::rsp_t                 rsp,
  input  logic [sppq_pkg::CAP_W-1:0]     capacity [sppq_pkg::NUM_LEVEL_REGS],
  input  logic [sppq_pkg::DELAY_W-1:0]   delay [sppq_pkg::NUM_LEVEL_REGS],
  output sppq_pkg::alu_req_t             alu_op,
  input  sppq_pkg::alu_rsp_t             alu_res,
  output logic                           mem_we,
  output logic [LVL_AW+PTR_W-1:0]        mem_waddr,
  output logic [sppq_pkg::ENTRY_W-1:0]   mem_wdata,
  output logic                           mem_re,
  output logic [LVL_AW+PTR_W-1:0]        mem_raddr,
  input  logic [sppq_pkg::ENTRY_W-1:0]   mem_rdata
);

  localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W    = (OCC_W > sppq_pkg::CAP_W) ? OCC_W : sppq_pkg::CAP_W;
  localparam int RECIP_SH = 16;
  localparam int RECIP    = ((1 << RECIP_SH) + LEVELS - 1) / LEVELS;
  localparam int PROD_W   = sppq_pkg::PRIO_W + RECIP_SH;

  sppq_pkg::state_t state, state_next;
  sppq_pkg::req_t   hold, hold_next;
  sppq_pkg::rsp_t   res, res_next;
  sppq_pkg::rsp_t   rsp_next;
  logic             rsp_valid_next;

  logic [sppq_pkg::LEVEL_W-1:0] cur, cur_next;
  logic [sppq_pkg::LEVEL_W-1:0] lvl, lvl_next;
  logic [OCC_W-1:0] occ [LEVELS];
  logic [OCC_W-1:0] occ_next [LEVELS];
  logic [PTR_W-1:0] head [LEVELS];
  logic [PTR_W-1:0] head_next [LEVELS];
  logic [PTR_W-1:0] tail [LEVELS];
  logic [PTR_W-1:0] tail_next [LEVELS];

  logic [PROD_W-1:0]            prod;
  logic [sppq_pkg::PRIO_W-1:0]  quo;
  logic [sppq_pkg::PRIO_W-1:0]  rem;
  logic [sppq_pkg::LEVEL_W-1:0] lvl_mod;
  logic [CMP_W-1:0]             cap_eff;
  logic                         lvl_full;
  logic [LVL_AW-1:0]            ci;
  logic [LVL_AW-1:0]            li;
  logic                         cur_last;

  // tag priority modulo level count by reciprocal multiply
  assign prod    = {{RECIP_SH{1'b0}}, hold.tag_priority} * PROD_W'(RECIP);
  assign quo     = prod[PROD_W-1:RECIP_SH];
  assign rem     = hold.tag_priority - quo * sppq_pkg::PRIO_W'(LEVELS);
  assign lvl_mod = rem[sppq_pkg::LEVEL_W-1:0];

  always_comb begin
    if (CMP_W'(capacity[lvl_mod]) > CMP_W'(QUEUE_DEPTH)) begin
      cap_eff = CMP_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = CMP_W'(capacity[lvl_mod]);
    end
  end

  assign lvl_full  = CMP_W'(occ[lvl_mod[LVL_AW-1:0]]) >= cap_eff;
  assign ci        = cur[LVL_AW-1:0];
  assign li        = lvl[LVL_AW-1:0];
  assign cur_last  = (cur == sppq_pkg::LEVEL_W'(LEVELS - 1));
  assign req_ready = (state == sppq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sppq_pkg::S_IDLE;
      rsp_valid <= 1'b0;
      cur       <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        occ[i]  <= '0;
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      cur       <= cur_next;
      occ       <= occ_next;
      head      <= head_next;
      tail      <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
    res  <= res_next;
    rsp  <= rsp_next;
    lvl  <= lvl_next;
  end

  always_comb begin
    state_next     = state;
    hold_next      = hold;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cur_next       = cur;
    lvl_next       = lvl;
    occ_next       = occ;
    head_next      = head;
    tail_next      = tail;

    alu_op.mode = sppq_pkg::ALU_ADD_SAT;
    alu_op.a    = hold.current_time;
    alu_op.b    = sppq_pkg::TIME_W'(delay[lvl]);

    mem_we    = 1'b0;
    mem_waddr = {li, tail[li]};
    mem_wdata = {hold.packet_handle, alu_res.sum};
    mem_re    = 1'b0;
    mem_raddr = {ci, head[ci]};

    unique case (state)
      sppq_pkg::S_IDLE: begin
        if (req_valid) begin
          hold_next  = req;
          cur_next   = '0;
          state_next = (req.kind == sppq_pkg::KIND_DEQ) ? sppq_pkg::S_DEQ_RD
                                                         : sppq_pkg::S_ENQ_CHK;
        end
      end
      sppq_pkg::S_ENQ_CHK: begin
        lvl_next = lvl_mod;
        priority if (!hold.has_tag) begin
          res_next   = '{sppq_pkg::ST_UNTAGGED, '0, '0};
          state_next = sppq_pkg::S_FINISH;
        end else if (hold.tag_port >= sppq_pkg::PORT_W'(PORT_COUNT)) begin
          res_next   = '{sppq_pkg::ST_BAD_PORT, '0, lvl_mod};
          state_next = sppq_pkg::S_FINISH;
        end else if (lvl_full) begin
          res_next   = '{sppq_pkg::ST_DROPPED, '0, lvl_mod};
          state_next = sppq_pkg::S_FINISH;
        end else begin
          state_next = sppq_pkg::S_ENQ_WR;
        end
      end
      sppq_pkg::S_ENQ_WR: begin
        mem_we        = 1'b1;
        tail_next[li] = (tail[li] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail[li] + 1'b1;
        occ_next[li]  = occ[li] + 1'b1;
        res_next      = '{sppq_pkg::ST_QUEUED, '0, lvl};
        state_next    = sppq_pkg::S_FINISH;
      end
      sppq_pkg::S_DEQ_RD: begin
        if (occ[ci] == '0) begin
          if (cur_last) begin
            res_next   = '{sppq_pkg::ST_NONE, '0, '0};
            state_next = sppq_pkg::S_FINISH;
          end else begin
            cur_next = cur + 1'b1;
          end
        end else begin
          mem_re     = 1'b1;
          state_next = sppq_pkg::S_DEQ_CMP;
        end
      end
      sppq_pkg::S_DEQ_CMP: begin
        alu_op.mode = sppq_pkg::ALU_CMP;
        alu_op.b    = mem_rdata[sppq_pkg::TIME_W-1:0];
        priority if (alu_res.carry) begin
          head_next[ci] = (head[ci] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head[ci] + 1'b1;
          occ_next[ci]  = occ[ci] - 1'b1;
          res_next      = '{sppq_pkg::ST_DEQUEUED,
                            mem_rdata[sppq_pkg::ENTRY_W-1:sppq_pkg::TIME_W], cur};
          state_next    = sppq_pkg::S_FINISH;
        end else if (cur_last) begin
          res_next   = '{sppq_pkg::ST_NONE, '0, '0};
          state_next = sppq_pkg::S_FINISH;
        end else begin
          cur_next   = cur + 1'b1;
          state_next = sppq_pkg::S_DEQ_RD;
        end
      end
      sppq_pkg::S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = sppq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sppq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/strict_priority_paced_queue_core_tb.sv
// testbench of the strict priority paced queue: request table, then random phases
`timescale 1ns / 1ps

module strict_priority_paced_queue_core_tb;

  localparam int NUM_LEVELS = sppq_pkg::LEVELS_DEFAULT;
  localparam int QDEPTH     = sppq_pkg::QUEUE_DEPTH_DEFAULT;
  localparam int PORTS      = sppq_pkg::PORT_COUNT_DEFAULT;
  localparam logic [sppq_pkg::TIME_W-1:0] TIME_MAX = {sppq_pkg::TIME_W{1'b1}};

  typedef struct {
    bit                      is_write;
    int                      reg_idx;
    logic [31:0]             reg_val;
    sppq_pkg::req_t          item;
    bit                      has_want;
    sppq_pkg::rsp_t          want;
  } step_t;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         req_valid = 1'b0;
  logic                         req_ready;
  sppq_pkg::req_t               req       = '0;
  logic                         rsp_valid;
  logic                         rsp_ready = 1'b0;
  sppq_pkg::rsp_t               rsp;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [sppq_pkg::PADDR_W-1:0] paddr     = '0;
  logic [sppq_pkg::PDATA_W-1:0] pwdata    = '0;
  logic [sppq_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  logic [sppq_pkg::CAP_W-1:0]    cap_reg     [NUM_LEVELS] = '{default: sppq_pkg::CAPACITY_RESET};
  logic [sppq_pkg::DELAY_W-1:0]  delay_reg   [NUM_LEVELS] = '{default: sppq_pkg::DELAY_RESET};
  logic [sppq_pkg::HANDLE_W-1:0] slot_handle [NUM_LEVELS][QDEPTH];
  logic [sppq_pkg::TIME_W-1:0]   slot_due    [NUM_LEVELS][QDEPTH];
  int                            fill        [NUM_LEVELS] = '{default: 0};
  int                            rd_ptr      [NUM_LEVELS] = '{default: 0};
  int                            wr_ptr      [NUM_LEVELS] = '{default: 0};

  sppq_pkg::rsp_t              pending_results[$];
  step_t                       plan[$];
  logic [sppq_pkg::TIME_W-1:0] now_ticks   = '0;
  bit                          steady      = 1'b0;
  int                          error_count = 0;

  strict_priority_paced_queue_core u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic sppq_pkg::rsp_t schedule_outcome(input sppq_pkg::req_t r);
    sppq_pkg::rsp_t            o;
    int                        lvl;
    int                        limit;
    int                        l;
    bit                        hit;
    logic [sppq_pkg::TIME_W:0] due;
    o.status     = sppq_pkg::ST_NONE;
    o.packet_out = '0;
    o.level_out  = '0;
    hit          = 1'b0;
    if (r.kind == sppq_pkg::KIND_ENQ) begin
      lvl = r.tag_priority % NUM_LEVELS;
      if (!r.has_tag) begin
        o.status = sppq_pkg::ST_UNTAGGED;
      end else begin
        o.level_out = sppq_pkg::LEVEL_W'(lvl);
        limit = (cap_reg[lvl] > QDEPTH) ? QDEPTH : int'(cap_reg[lvl]);
        if (r.tag_port >= PORTS) begin
          o.status = sppq_pkg::ST_BAD_PORT;
        end else if (fill[lvl] >= limit) begin
          o.status = sppq_pkg::ST_DROPPED;
        end else begin
          due = {1'b0, r.current_time} + delay_reg[lvl];
          slot_handle[lvl][wr_ptr[lvl]] = r.packet_handle;
          slot_due[lvl][wr_ptr[lvl]] = due[sppq_pkg::TIME_W] ? TIME_MAX
                                                             : due[sppq_pkg::TIME_W-1:0];
          wr_ptr[lvl] = (wr_ptr[lvl] + 1) % QDEPTH;
          fill[lvl]++;
          o.status = sppq_pkg::ST_QUEUED;
        end
      end
    end else begin
      for (l = 0; l < NUM_LEVELS; l++) begin
        if (!hit && fill[l] != 0 && slot_due[l][rd_ptr[l]] <= r.current_time) begin
          hit          = 1'b1;
          o.status     = sppq_pkg::ST_DEQUEUED;
          o.packet_out = slot_handle[l][rd_ptr[l]];
          o.level_out  = sppq_pkg::LEVEL_W'(l);
          rd_ptr[l]    = (rd_ptr[l] + 1) % QDEPTH;
          fill[l]--;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin : rsp_check
    sppq_pkg::rsp_t want;
    if (rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        report_error("result with none outstanding", rsp, 0);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status)
          report_error("status", rsp.status, want.status);
        if (rsp.packet_out !== want.packet_out)
          report_error("packet_out", rsp.packet_out, want.packet_out);
        if (rsp.level_out !== want.level_out)
          report_error("level_out", rsp.level_out, want.level_out);
      end
    end
    rsp_ready <= steady || ($urandom_range(99) >= 32);
  end

  task automatic send_item(input sppq_pkg::req_t r, input bit has_want,
                           input sppq_pkg::rsp_t want);
    sppq_pkg::rsp_t pred;
    while (!steady && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    pred = schedule_outcome(r);
    pending_results.push_back(has_want ? want : pred);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sppq_pkg::PADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < sppq_pkg::REG_DELAY_BASE)
      cap_reg[idx - sppq_pkg::REG_CAPACITY_BASE] = val[sppq_pkg::CAP_W-1:0];
    else delay_reg[idx - sppq_pkg::REG_DELAY_BASE] = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) report_error("register readback", prdata, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_capacity();
    unique case ($urandom_range(4))
      0:       return 32'd0;
      1:       return $urandom_range(3, 1);
      2:       return $urandom_range(QDEPTH);
      3:       return 32'(sppq_pkg::CAPACITY_RESET);
      default: return $urandom_range(127, QDEPTH + 1);
    endcase
  endfunction

  function automatic sppq_pkg::req_t random_req(input int enq_pct, input int hot_lvl,
                                                input int hot_pct);
    sppq_pkg::req_t r;
    r.kind          = ($urandom_range(99) < enq_pct) ? sppq_pkg::KIND_ENQ : sppq_pkg::KIND_DEQ;
    r.current_time  = now_ticks;
    r.has_tag       = ($urandom_range(99) >= 8);
    r.tag_priority  = 8'($urandom_range(255));
    if (hot_lvl >= 0 && $urandom_range(99) < hot_pct)
      r.tag_priority = {6'($urandom_range(63)), 2'(hot_lvl)};
    r.tag_port      = ($urandom_range(99) < 8) ? 16'($urandom_range(65535, PORTS))
                                               : 16'($urandom_range(PORTS - 1));
    r.packet_handle = 16'($urandom_range(65535));
    return r;
  endfunction

  task automatic run_phase(input int n, input int enq_pct, input int hot_lvl,
                           input int hot_pct, input int step_max);
    sppq_pkg::rsp_t none;
    none = '{status: sppq_pkg::ST_NONE, packet_out: '0, level_out: '0};
    repeat (n) begin
      now_ticks = now_ticks + $urandom_range(step_max);
      send_item(random_req(enq_pct, hot_lvl, hot_pct), 1'b0, none);
    end
  endtask

  function automatic step_t enq_row(input logic [sppq_pkg::TIME_W-1:0] t, input logic tag,
                                    input logic [7:0] prio, input logic [15:0] port,
                                    input logic [15:0] handle);
    step_t s;
    s.is_write            = 1'b0;
    s.reg_idx             = 0;
    s.reg_val             = '0;
    s.item.kind           = sppq_pkg::KIND_ENQ;
    s.item.current_time   = t;
    s.item.has_tag        = tag;
    s.item.tag_priority   = prio;
    s.item.tag_port       = port;
    s.item.packet_handle  = handle;
    s.has_want            = 1'b0;
    s.want.status         = sppq_pkg::ST_NONE;
    s.want.packet_out     = '0;
    s.want.level_out      = '0;
    return s;
  endfunction

  function automatic step_t deq_row(input logic [sppq_pkg::TIME_W-1:0] t);
    step_t s;
    s = enq_row(t, 1'b1, 8'hff, 16'hffff, 16'hc3c3);
    s.item.kind = sppq_pkg::KIND_DEQ;
    return s;
  endfunction

  function automatic step_t cfg_row(input int idx, input logic [31:0] val);
    step_t s;
    s = enq_row('0, 1'b0, '0, '0, '0);
    s.is_write = 1'b1;
    s.reg_idx  = idx;
    s.reg_val  = val;
    return s;
  endfunction

  function automatic step_t with_want(input step_t s, input sppq_pkg::status_t st,
                                      input logic [15:0] pkt, input logic [1:0] lvl);
    step_t o;
    o                 = s;
    o.has_want        = 1'b1;
    o.want.status     = st;
    o.want.packet_out = pkt;
    o.want.level_out  = lvl;
    return o;
  endfunction

  initial begin
    #5000000;
    $display("strict_priority_paced_queue_core: mismatch");
    $finish;
  end

  initial begin
    int i;
    plan.push_back(with_want(deq_row(0), sppq_pkg::ST_NONE, 16'h0, 2'd0));
    plan.push_back(with_want(enq_row(0, 1'b0, 8'd255, 16'hffff, 16'hffff),
                             sppq_pkg::ST_UNTAGGED, 16'h0, 2'd0));
    plan.push_back(with_want(enq_row(1, 1'b1, 8'd255, 16'd16, 16'h1111),
                             sppq_pkg::ST_BAD_PORT, 16'h0, 2'd3));
    plan.push_back(with_want(enq_row(1, 1'b1, 8'd0, 16'hffff, 16'h0000),
                             sppq_pkg::ST_BAD_PORT, 16'h0, 2'd0));
    plan.push_back(with_want(enq_row(2, 1'b1, 8'd7, 16'd15, 16'hffff),
                             sppq_pkg::ST_QUEUED, 16'h0, 2'd3));
    plan.push_back(with_want(enq_row(2, 1'b1, 8'd4, 16'd0, 16'h0000),
                             sppq_pkg::ST_QUEUED, 16'h0, 2'd0));
    plan.push_back(with_want(deq_row(2), sppq_pkg::ST_DEQUEUED, 16'h0000, 2'd0));
    plan.push_back(with_want(deq_row(3), sppq_pkg::ST_DEQUEUED, 16'hffff, 2'd3));
    plan.push_back(cfg_row(sppq_pkg::REG_CAPACITY_BASE + 1, 32'd0));
    plan.push_back(cfg_row(sppq_pkg::REG_DELAY_BASE + 0, 32'd100));
    plan.push_back(cfg_row(sppq_pkg::REG_DELAY_BASE + 2, 32'd10));
    // zero capacity drops, a head not yet due lets later levels through
    plan.push_back(with_want(enq_row(5, 1'b1, 8'd1, 16'd3, 16'h2222),
                             sppq_pkg::ST_DROPPED, 16'h0, 2'd1));
    plan.push_back(enq_row(5, 1'b1, 8'd2, 16'd4, 16'h1234));
    plan.push_back(enq_row(6, 1'b1, 8'd0, 16'd5, 16'h5678));
    plan.push_back(enq_row(6, 1'b1, 8'd3, 16'd6, 16'h9abc));
    plan.push_back(with_want(deq_row(7), sppq_pkg::ST_DEQUEUED, 16'h9abc, 2'd3));
    plan.push_back(with_want(deq_row(14), sppq_pkg::ST_NONE, 16'h0, 2'd0));
    plan.push_back(with_want(deq_row(15), sppq_pkg::ST_DEQUEUED, 16'h1234, 2'd2));
    plan.push_back(deq_row(106));
    plan.push_back(cfg_row(sppq_pkg::REG_CAPACITY_BASE + 2, 32'd2));
    plan.push_back(cfg_row(sppq_pkg::REG_CAPACITY_BASE + 3, 32'd127));
    plan.push_back(cfg_row(sppq_pkg::REG_DELAY_BASE + 2, 32'd0));
    plan.push_back(enq_row(200, 1'b1, 8'd2, 16'd7, 16'haaaa));
    plan.push_back(enq_row(200, 1'b1, 8'd6, 16'd8, 16'hbbbb));
    plan.push_back(with_want(enq_row(200, 1'b1, 8'd10, 16'd9, 16'hcccc),
                             sppq_pkg::ST_DROPPED, 16'h0, 2'd2));
    plan.push_back(enq_row(201, 1'b1, 8'd131, 16'd15, 16'hdddd));
    plan.push_back(deq_row(201));
    plan.push_back(deq_row(201));
    plan.push_back(deq_row(201));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        wait_idle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        send_item(plan[k].item, plan[k].has_want, plan[k].want);
      end
    end
    now_ticks = 48'd300;

    wait_idle();
    for (i = 0; i < NUM_LEVELS; i++) begin
      write_reg(sppq_pkg::REG_CAPACITY_BASE + i, 32'(sppq_pkg::CAPACITY_RESET));
      write_reg(sppq_pkg::REG_DELAY_BASE + i, $urandom_range(30));
    end
    run_phase(100, 55, -1, 0, 8);

    wait_idle();
    for (i = 0; i < NUM_LEVELS; i++) begin
      write_reg(sppq_pkg::REG_CAPACITY_BASE + i, pick_capacity());
      write_reg(sppq_pkg::REG_DELAY_BASE + i, $urandom_range(1) ? $urandom_range(60) : 0);
    end
    steady = 1'b1;
    run_phase(100, 60, -1, 0, 10);
    steady = 1'b0;

    // fill one level up to its depth (capacity 127 is above it), then drain so the pointers wrap
    wait_idle();
    for (i = 0; i < NUM_LEVELS; i++) begin
      write_reg(sppq_pkg::REG_CAPACITY_BASE + i, pick_capacity());
      write_reg(sppq_pkg::REG_DELAY_BASE + i, 32'd0);
    end
    write_reg(sppq_pkg::REG_CAPACITY_BASE + 3, 32'd127);
    run_phase(130, 85, 3, 90, 4);
    run_phase(90, 20, 3, 50, 4);

    wait_idle();
    for (i = 0; i < NUM_LEVELS; i++) begin
      write_reg(sppq_pkg::REG_CAPACITY_BASE + i, pick_capacity());
      write_reg(sppq_pkg::REG_DELAY_BASE + i, $urandom_range(500));
    end
    run_phase(80, 50, -1, 0, 40);

    // near the end of time, release times saturate
    wait_idle();
    for (i = 0; i < NUM_LEVELS; i++) begin
      write_reg(sppq_pkg::REG_CAPACITY_BASE + i, 32'(sppq_pkg::CAPACITY_RESET));
      write_reg(sppq_pkg::REG_DELAY_BASE + i,
                (i % 2 == 0) ? 32'hffff_ffff : $urandom_range(1000));
    end
    now_ticks = TIME_MAX - 48'd5000;
    run_phase(30, 60, -1, 0, 100);
    now_ticks = TIME_MAX;
    run_phase(16, 30, -1, 0, 0);

    wait_idle();
    if (error_count == 0) begin
      $display("strict_priority_paced_queue_core: match");
    end else begin
      $display("strict_priority_paced_queue_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/sppq_pkg.sv
design/sppq_alu.sv
design/sppq_store.sv
design/sppq_seq.sv
design/strict_priority_paced_queue_core.sv
tb/strict_priority_paced_queue_core_tb.sv
